// ----- rtl/core/sahs_pkg.sv -----
`default_nettype none
package sahs_pkg;

  localparam int TableSlots = 4096;
  localparam int SlotW = $clog2(TableSlots);
  localparam int CountW = 13;
  localparam int KeyW = 64;
  localparam int MarkW = 2;
  localparam int MixShift = 33;
  localparam int HalfW = 32;
  localparam logic [KeyW-1:0] MixMul = 64'hff51afd7ed558ccd;
  localparam int QDepth = 2;

  typedef enum logic [0:0] {
    OP_ADD = 1'b0,
    OP_DEL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_OCCUPIED = 2'd1,
    MARK_DELETED  = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] dest_addr;
    logic [31:0] sec_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] installed_count;
  } out_item_t;

  // hashed request handed from front to back
  typedef struct packed {
    logic            is_del;
    logic [KeyW-1:0] key;
    logic [SlotW-1:0] start;
  } job_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MUL_LO,
    FS_MUL_HI,
    FS_FOLD
  } front_state_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ,
    BS_CHECK,
    BS_WRITE,
    BS_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/sa_hash_set_linear_probe.sv -----
`default_nettype none
// Set of 64-bit SA keys ({dest_addr, sec_index}) in a 4096-slot open-addressed
// table with linear probing. The front hashes a request (two-part 64-bit
// multiply) and hands it through a 2-entry queue to the back, which takes it,
// walks the table one probed slot at a time (registered RAM read, then
// compare), installs the key in the first free slot seen when an add ends its
// walk without a match and then presents the result; hashing of the next
// request overlaps the work of the back. After reset the back clears all 4096
// slot marks, one per cycle, before its first lookup; requests are queued
// meanwhile.
module sa_hash_set_linear_probe (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sahs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sahs_pkg::out_item_t      out_data
);
  import sahs_pkg::*;

  logic f_valid, f_stall, q_valid, q_take;
  job_t f_job, q_job;

  sahs_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid(f_valid), .job_stall(f_stall), .job_data(f_job)
  );
  sahs_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_job)
  );
  sahs_back u_back (
    .clk, .rst_n, .job_valid(q_valid), .job_take(q_take), .job_data(q_job),
    .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire

// ----- rtl/core/sahs_ram.sv -----
`default_nettype none
module sahs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/sahs_front.sv -----
`default_nettype none
module sahs_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sahs_pkg::in_item_t in_data,
  output logic                   job_valid,
  input  wire logic              job_stall,
  output sahs_pkg::job_t         job_data
);
  import sahs_pkg::*;

  front_state_t state_r, state_nxt;
  logic [KeyW-1:0] key_r, mix_r, prod_r, prod_nxt;
  logic is_del_r;
  logic [KeyW-1:0] mix_nxt, fold;
  logic [KeyW-1:0] pp_lo;
  logic [HalfW-1:0] pp_cross;

  assign in_stall = (state_r != FS_IDLE);
  assign mix_nxt = {in_data.dest_addr, in_data.sec_index} ^
                   ({in_data.dest_addr, in_data.sec_index} >> MixShift);
  assign fold = prod_r ^ (prod_r >> MixShift);

  assign pp_lo = 64'(mix_r[31:0]) * 64'(MixMul[31:0]);
  assign pp_cross = mix_r[31:0] * MixMul[63:32] + mix_r[63:32] * MixMul[31:0];

  // 64x64 mod 2^64 product, built up in FS_MUL_LO (low x low) and then FS_MUL_HI
  // (both cross terms into the high half)
  always_comb begin
    prod_nxt = prod_r;
    case (state_r)
      FS_MUL_LO: prod_nxt = pp_lo;
      FS_MUL_HI: prod_nxt = prod_r + {pp_cross, 32'd0};
      default: prod_nxt = prod_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE:   if (in_valid) state_nxt = FS_MUL_LO;
      FS_MUL_LO: state_nxt = FS_MUL_HI;
      FS_MUL_HI: state_nxt = FS_FOLD;
      FS_FOLD:   if (!job_stall) state_nxt = FS_IDLE;
      default:   state_nxt = FS_IDLE;
    endcase
  end

  assign job_valid = (state_r == FS_FOLD);
  assign job_data = '{is_del: is_del_r, key: key_r, start: fold[SlotW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    prod_r <= prod_nxt;
    if (state_r == FS_IDLE && in_valid) begin
      key_r <= {in_data.dest_addr, in_data.sec_index};
      mix_r <= mix_nxt;
      is_del_r <= in_data.opcode;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/sahs_queue.sv -----
`default_nettype none
module sahs_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_stall,
  input  wire sahs_pkg::job_t  wr_data,
  output logic                 rd_valid,
  input  wire logic            rd_take,
  output sahs_pkg::job_t       rd_data
);
  import sahs_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  job_t buf_r [QDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0] cnt_r;
  logic push, pop;

  assign wr_stall = (cnt_r == (PtrW+1)'(QDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data = buf_r[rp_r];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
    if (push) buf_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

// ----- rtl/core/sahs_back.sv -----
`default_nettype none
module sahs_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_valid,
  output logic                  job_take,
  input  wire sahs_pkg::job_t   job_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output sahs_pkg::out_item_t   out_data
);
  import sahs_pkg::*;

  back_state_t state_r, state_nxt;
  logic is_del_r;
  logic [KeyW-1:0] key_r;
  logic [SlotW-1:0] pos_r, pos_nxt, free_pos_r, free_pos_nxt;
  logic free_seen_r, free_seen_nxt;
  logic [SlotW:0] steps_r, steps_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [1:0] status_r, status_nxt;

  logic mk_we, ky_we;
  logic [SlotW-1:0] mk_waddr, rd_addr;
  logic [MarkW-1:0] mk_wdata, mk_rdata;
  logic [KeyW-1:0] ky_rdata;
  logic found;

  sahs_ram #(.Width(MarkW), .Depth(TableSlots)) u_mark (
    .clk, .wr_en(mk_we), .wr_addr(mk_waddr), .wr_data(mk_wdata),
    .rd_addr(rd_addr), .rd_data(mk_rdata)
  );
  sahs_ram #(.Width(KeyW), .Depth(TableSlots)) u_key (
    .clk, .wr_en(ky_we), .wr_addr(free_pos_r), .wr_data(key_r),
    .rd_addr(rd_addr), .rd_data(ky_rdata)
  );

  assign rd_addr = pos_r;
  assign found = (mk_rdata == MARK_OCCUPIED) && (ky_rdata == key_r);
  assign out_valid = (state_r == BS_OUT);
  assign out_data = '{status: status_r, installed_count: count_r};
  assign job_take = (state_r == BS_IDLE);

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    free_pos_nxt = free_pos_r;
    free_seen_nxt = free_seen_r;
    steps_nxt = steps_r;
    count_nxt = count_r;
    status_nxt = status_r;
    mk_we = 1'b0;
    ky_we = 1'b0;
    mk_waddr = pos_r;
    mk_wdata = MARK_EMPTY;
    case (state_r)
      BS_CLEAR: begin
        // sweep marks to empty after reset
        mk_we = 1'b1;
        pos_nxt = pos_r + 1'b1;
        if (pos_r == SlotW'(TableSlots - 1)) state_nxt = BS_IDLE;
      end
      BS_IDLE: begin
        if (job_valid) begin
          pos_nxt = job_data.start;
          free_seen_nxt = 1'b0;
          steps_nxt = '0;
          state_nxt = BS_READ;
        end
      end
      BS_READ: state_nxt = BS_CHECK;
      BS_CHECK: begin
        if (found) begin
          if (is_del_r) begin
            mk_we = 1'b1;
            mk_wdata = MARK_DELETED;
            count_nxt = count_r - 1'b1;
            status_nxt = ST_OK;
          end else begin
            status_nxt = ST_PRESENT;
          end
          state_nxt = BS_OUT;
        end else begin
          if (mk_rdata != MARK_OCCUPIED && !free_seen_r) begin
            free_seen_nxt = 1'b1;
            free_pos_nxt = pos_r;
          end
          if (mk_rdata == MARK_EMPTY ||
              steps_r == (SlotW+1)'(TableSlots - 1)) begin
            state_nxt = BS_WRITE;
          end else begin
            pos_nxt = pos_r + 1'b1;
            steps_nxt = steps_r + 1'b1;
            state_nxt = BS_READ;
          end
        end
      end
      BS_WRITE: begin
        if (is_del_r) begin
          status_nxt = ST_NOT_FOUND;
        end else if (free_seen_r) begin
          mk_we = 1'b1;
          ky_we = 1'b1;
          mk_waddr = free_pos_r;
          mk_wdata = MARK_OCCUPIED;
          count_nxt = count_r + 1'b1;
          status_nxt = ST_OK;
        end else begin
          status_nxt = ST_FULL;
        end
        state_nxt = BS_OUT;
      end
      BS_OUT: if (!out_stall) state_nxt = BS_IDLE;
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_CLEAR;
      pos_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      count_r <= count_nxt;
    end
    free_pos_r <= free_pos_nxt;
    free_seen_r <= free_seen_nxt;
    steps_r <= steps_nxt;
    status_r <= status_nxt;
    if (state_r == BS_IDLE && job_valid) begin
      is_del_r <= job_data.is_del;
      key_r <= job_data.key;
    end
  end
endmodule
`default_nettype wire

// ----- tb/tb_sa_hash_set_linear_probe.sv -----
`timescale 1ns / 1ps
module tb_sa_hash_set_linear_probe;
  import sahs_pkg::*;

  localparam int SlotMask = TableSlots - 1;
  localparam int IdleLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // shadow copy of the table
  logic [KeyW-1:0] shadow_key [TableSlots];
  mark_t shadow_mark [TableSlots];
  int unsigned shadow_count;
  out_item_t expected_q[$];

  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  bit stall_random = 1'b1;
  int status_hits[4] = '{0, 0, 0, 0};
  logic [KeyW-1:0] live_keys[$];

  sa_hash_set_linear_probe u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [SlotW-1:0] start_slot(logic [KeyW-1:0] k);
    logic [KeyW-1:0] h;
    h = k ^ (k >> MixShift);
    h = h * MixMul;
    h = h ^ (h >> MixShift);
    return h[SlotW-1:0];
  endfunction

  function automatic out_item_t apply_request(in_item_t req);
    logic [KeyW-1:0] k;
    int unsigned pos;
    int unsigned free_pos;
    bit free_seen;
    bit found;
    logic [1:0] st;
    out_item_t res;
    k = {req.dest_addr, req.sec_index};
    pos = 32'(start_slot(k));
    free_seen = 1'b0;
    free_pos = 0;
    found = 1'b0;
    for (int n = 0; n < TableSlots; n++) begin
      if (shadow_mark[pos] == MARK_OCCUPIED && shadow_key[pos] == k) begin
        found = 1'b1;
        break;
      end
      if (shadow_mark[pos] != MARK_OCCUPIED && !free_seen) begin
        free_seen = 1'b1;
        free_pos = pos;
      end
      if (shadow_mark[pos] == MARK_EMPTY) break;
      pos = (pos + 1) & SlotMask;
    end
    if (req.opcode == OP_DEL) begin
      if (found) begin
        shadow_mark[pos] = MARK_DELETED;
        shadow_count--;
        st = ST_OK;
      end else begin
        st = ST_NOT_FOUND;
      end
    end else if (found) begin
      st = ST_PRESENT;
    end else if (free_seen) begin
      shadow_key[free_pos] = k;
      shadow_mark[free_pos] = MARK_OCCUPIED;
      shadow_count++;
      st = ST_OK;
    end else begin
      st = ST_FULL;
    end
    res.status = st;
    res.installed_count = shadow_count[12:0];
    return res;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(logic op, logic [31:0] daddr, logic [31:0] spi, bit gaps);
    in_item_t req;
    int gap;
    req.opcode = op;
    req.dest_addr = daddr;
    req.sec_index = spi;
    gap = gaps ? pick_gap() : 0;
    // drop valid only for a gap before this request; back to back keeps it high
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(apply_request(req));
    requests_sent++;
    if (op == OP_ADD) live_keys.push_back({daddr, spi});
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        exp_res = expected_q.pop_front();
        status_hits[exp_res.status]++;
        if (out_data.status !== exp_res.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, exp_res.status));
        if (out_data.installed_count !== exp_res.installed_count)
          report_mismatch($sformatf("count got %0d want %0d",
                                    out_data.installed_count, exp_res.installed_count));
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (stall_random) begin
      if ($urandom_range(0, 99) < 2) hold_cycles <= $urandom_range(10, 40);
      out_stall <= ($urandom_range(0, 99) < 25);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no progress for %0d cycles", IdleLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(OP_DEL, 32'h0, 32'h0, 1'b0);
    send_request(OP_ADD, 32'h0, 32'h0, 1'b0);
    send_request(OP_ADD, 32'h0, 32'h0, 1'b0);
    send_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_ADD, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_request(OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_request(OP_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_DEL, 32'h0, 32'h0, 1'b0);
    send_request(OP_ADD, 32'h0, 32'h1, 1'b0);
    send_request(OP_DEL, 32'h8000_0000, 32'h8000_0000, 1'b0);
  endtask

  task automatic random_key(output logic [31:0] d, output logic [31:0] s);
    logic [KeyW-1:0] k;
    if (live_keys.size() > 0 && $urandom_range(0, 99) < 45) begin
      k = live_keys[$urandom_range(0, live_keys.size() - 1)];
      d = k[63:32];
      s = k[31:0];
    end else begin
      d = $urandom();
      s = $urandom();
    end
  endtask

  task automatic test_random_mix(int count);
    logic [31:0] d, s;
    for (int i = 0; i < count; i++) begin
      random_key(d, s);
      send_request(($urandom_range(0, 99) < 60) ? OP_ADD : OP_DEL, d, s, 1'b1);
    end
  endtask

  // long receiver hold while back-to-back requests fill the block
  task automatic test_backpressure();
    logic [31:0] d, s;
    in_valid <= 1'b0;
    stall_random = 1'b0;
    wait (hold_cycles == 0);
    @(negedge clk);
    hold_cycles = 300;
    @(posedge clk);
    for (int i = 0; i < 40; i++) begin
      random_key(d, s);
      send_request(1'($urandom_range(0, 1)), d, s, 1'b0);
    end
    stall_random = 1'b1;
  endtask

  task automatic test_heavy_load();
    logic [31:0] d, s;
    // raise the table fill, with some churn, so probes run longer
    for (int i = 0; i < 700; i++) begin
      random_key(d, s);
      send_request(($urandom_range(0, 99) < 85) ? OP_ADD : OP_DEL, d, s, 1'b1);
    end
  endtask

  initial begin
    for (int i = 0; i < TableSlots; i++) begin
      shadow_key[i] = '0;
      shadow_mark[i] = MARK_EMPTY;
    end
    shadow_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(700);
    test_backpressure();
    test_heavy_load();
    test_random_mix(250);
    in_valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d requests, %0d results, table fill %0d of %0d slots",
             requests_sent, results_seen, shadow_count, TableSlots);
    $display("Status counts: ok %0d present %0d full %0d not-found %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
